>>> hw/rtl/ose_pkg.sv
// ----------------------------------------------------------------------------
// ose_pkg: shared types and constants of the one-shot event timer table
// Result kinds, shared adder operations, sequencer states and the result
// record carried by the output register.
// ----------------------------------------------------------------------------
`default_nettype none

package ose_pkg;

    // Default table geometry
    localparam int SLOT_COUNT_DEF = 32;
    localparam int TAG_BITS_DEF   = 16;

    // A tick reports at most this many fired events
    localparam int MAX_RESULTS = 32;

    // Fixed field widths of the ports
    localparam int DELAY_BITS   = 32;
    localparam int TAG_IN_BITS  = 16;
    localparam int TAG_OUT_BITS = 16;
    localparam int SLOT_BITS    = 5;
    localparam int TIME_BITS    = 64;

    typedef enum logic [1:0] {
        RK_ADD_OK   = 2'd0,
        RK_ADD_FULL = 2'd1,
        RK_FIRED    = 2'd2,
        RK_NONE_DUE = 2'd3
    } t_kind;

    // Operations of the shared 64-bit adder
    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,   // a + b
        ALU_INC = 2'd1,   // a + 1
        ALU_SUB = 2'd2    // a - b, carry set when a >= b
    } t_alu_op;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_ADD   = 3'd1,
        ST_INC   = 3'd2,
        ST_SCAN  = 3'd3,
        ST_FLUSH = 3'd4
    } t_state;

    typedef struct packed {
        t_kind                     kind;
        logic [SLOT_BITS-1:0]      slot;
        logic [TAG_OUT_BITS-1:0]   tag;
        logic                      last;
    } t_result;

endpackage

`default_nettype wire

>>> hw/rtl/ose_alu.sv
// ----------------------------------------------------------------------------
// ose_alu: shared 64-bit adder
// One carry-out adder serves the due-time sum, the time increment and the
// due compare (subtract, carry out means no borrow).
// ----------------------------------------------------------------------------
`default_nettype none

module ose_alu
    import ose_pkg::*;
(
    input  wire t_alu_op              i_op,
    input  wire logic [TIME_BITS-1:0] i_a,
    input  wire logic [TIME_BITS-1:0] i_b,
    output logic      [TIME_BITS-1:0] o_sum,
    output logic                      o_carry
);

    logic [TIME_BITS-1:0] b_opnd;
    logic                 cin;

    // Select second operand and carry in
    always_comb begin
        unique case (i_op)
            ALU_ADD: begin
                b_opnd = i_b;
                cin    = 1'b0;
            end
            ALU_INC: begin
                b_opnd = '0;
                cin    = 1'b1;
            end
            ALU_SUB: begin
                b_opnd = ~i_b;
                cin    = 1'b1;
            end
            default: begin
                b_opnd = i_b;
                cin    = 1'b0;
            end
        endcase
    end

    // Add with carry out
    assign {o_carry, o_sum} = {1'b0, i_a} + {1'b0, b_opnd} + {{TIME_BITS{1'b0}}, cin};

endmodule

`default_nettype wire

>>> hw/rtl/ose_slot_mem.sv
// ----------------------------------------------------------------------------
// ose_slot_mem: slot table memory
// One write port and one read port with registered read data; each entry
// holds the due time and the tag of one slot.
// ----------------------------------------------------------------------------
`default_nettype none

module ose_slot_mem
    import ose_pkg::*;
#(
    parameter int DEPTH = SLOT_COUNT_DEF,
    parameter int AW    = 5,
    parameter int DW    = TIME_BITS + TAG_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/one_shot_event_timer_table_core.sv
// ----------------------------------------------------------------------------
// one_shot_event_timer_table_core: one-shot event timer table
// Keeps a 64-bit tick count and a table of one-shot events; adds events and
// reports the events that fall due on each tick.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one request: an add
//   (i_operation = 0) with i_delay and i_event_tag, or a tick (i_operation = 1).
//   Output channel (o_out_valid / i_out_ready) carries results; o_last marks
//   the final result of a request.
//   An add drives its single result valid from ST_ADD once the output register
//   is free, then returns to idle for the next request: it stores the tag in
//   the next unused slot, due at now + delay, or reports the table full.
//   A tick increments time in ST_INC, then in ST_SCAN reads each used slot
//   from memory and finishes its compare through the shared 64-bit adder,
//   and drives its last result from ST_FLUSH; it then returns to idle for
//   the next request.
//   Only one request is in work at a time; o_in_ready is high only when idle.
//   A stalled receiver holds the scan in place while the output register and
//   one pending result are full; nothing is dropped.
//   Reset clears time, the used-slot count and all active flags; slot contents
//   are written before they are ever compared, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module one_shot_event_timer_table_core
    import ose_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int TAG_BITS   = TAG_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic                    i_operation,
    input  wire logic [DELAY_BITS-1:0]   i_delay,
    input  wire logic [TAG_IN_BITS-1:0]  i_event_tag,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic [1:0]                   o_result_kind,
    output logic [SLOT_BITS-1:0]         o_slot,
    output logic [TAG_OUT_BITS-1:0]      o_fired_tag,
    output logic                         o_last
);

    // Slot index, slot count, fire count and stored tag widths
    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int RW = $clog2(MAX_RESULTS + 1);
    localparam int SW = (TAG_BITS < TAG_IN_BITS) ? TAG_BITS : TAG_IN_BITS;
    localparam int DW = TIME_BITS + SW;

    t_state                r_state, n_state;
    logic [TIME_BITS-1:0]  r_now, n_now;
    logic [CW-1:0]         r_used, n_used;
    logic [SLOT_COUNT-1:0] r_active, n_active;
    logic [CW-1:0]         r_idx, n_idx;
    logic                  r_cmp_valid, n_cmp_valid;
    logic [IW-1:0]         r_cmp_idx, n_cmp_idx;
    logic [RW-1:0]         r_fire_cnt, n_fire_cnt;
    logic                  r_p_valid, n_p_valid;
    logic [IW-1:0]         r_p_slot, n_p_slot;
    logic [SW-1:0]         r_p_tag, n_p_tag;
    logic                  r_out_valid, n_out_valid;
    t_result               r_out, n_out;
    logic [DELAY_BITS-1:0] r_delay, n_delay;
    logic [SW-1:0]         r_tag, n_tag;

    t_alu_op               alu_op;
    logic [TIME_BITS-1:0]  alu_b;
    logic [TIME_BITS-1:0]  alu_sum;
    logic                  alu_carry;
    logic                  mem_we;
    logic [IW-1:0]         mem_waddr;
    logic [DW-1:0]         mem_wdata;
    logic [IW-1:0]         mem_raddr;
    logic [DW-1:0]         mem_rdata;
    logic [TIME_BITS-1:0]  rd_due;
    logic [SW-1:0]         rd_tag;
    logic                  out_free;
    logic                  fire;
    logic                  stall;

    // Shared adder
    ose_alu u_alu (
        .i_op    (alu_op),
        .i_a     (r_now),
        .i_b     (alu_b),
        .o_sum   (alu_sum),
        .o_carry (alu_carry)
    );

    // Slot table
    ose_slot_mem #(
        .DEPTH (SLOT_COUNT),
        .AW    (IW),
        .DW    (DW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign rd_due   = mem_rdata[SW +: TIME_BITS];
    assign rd_tag   = mem_rdata[SW-1:0];
    assign out_free = !r_out_valid || i_out_ready;

    assign o_in_ready    = (r_state == ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_out.kind;
    assign o_slot        = r_out.slot;
    assign o_fired_tag   = r_out.tag;
    assign o_last        = r_out.last;

    // Sequencer: next state and datapath controls
    always_comb begin
        n_state     = r_state;
        n_now       = r_now;
        n_used      = r_used;
        n_active    = r_active;
        n_idx       = r_idx;
        n_cmp_valid = r_cmp_valid;
        n_cmp_idx   = r_cmp_idx;
        n_fire_cnt  = r_fire_cnt;
        n_p_valid   = r_p_valid;
        n_p_slot    = r_p_slot;
        n_p_tag     = r_p_tag;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        n_delay     = r_delay;
        n_tag       = r_tag;
        alu_op      = ALU_ADD;
        alu_b       = TIME_BITS'(r_delay);
        mem_we      = 1'b0;
        mem_waddr   = r_used[IW-1:0];
        mem_wdata   = {alu_sum, r_tag};
        mem_raddr   = r_idx[IW-1:0];
        fire        = 1'b0;
        stall       = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                // Latch the request
                if (i_in_valid) begin
                    n_delay = i_delay;
                    n_tag   = i_event_tag[SW-1:0];
                    n_state = i_operation ? ST_INC : ST_ADD;
                end
            end

            ST_ADD: begin
                // Store the event at now + delay, or reject when full
                alu_op = ALU_ADD;
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_used >= CW'(SLOT_COUNT)) begin
                        n_out = '{kind: RK_ADD_FULL, slot: '0, tag: '0, last: 1'b1};
                    end else begin
                        mem_we                    = 1'b1;
                        n_active[r_used[IW-1:0]]  = 1'b1;
                        n_used                    = CW'(r_used + 1'b1);
                        n_out = '{kind: RK_ADD_OK, slot: SLOT_BITS'(r_used[IW-1:0]),
                                  tag: '0, last: 1'b1};
                    end
                    n_state = ST_IDLE;
                end
            end

            ST_INC: begin
                // Advance time and start the scan
                alu_op      = ALU_INC;
                n_now       = alu_sum;
                n_idx       = '0;
                n_cmp_valid = 1'b0;
                n_fire_cnt  = '0;
                n_state     = ST_SCAN;
            end

            ST_SCAN: begin
                // Compare one slot per cycle unless stalled: now - due without borrow means due
                alu_op = ALU_SUB;
                alu_b  = rd_due;
                fire   = r_cmp_valid && r_active[r_cmp_idx] && alu_carry
                         && (r_fire_cnt < RW'(MAX_RESULTS));
                stall  = fire && r_p_valid && !out_free;
                if (stall) begin
                    // Hold: re-read the slot under compare
                    mem_raddr = r_cmp_idx;
                end else begin
                    if (fire) begin
                        if (r_p_valid) begin
                            n_out_valid = 1'b1;
                            n_out = '{kind: RK_FIRED, slot: SLOT_BITS'(r_p_slot),
                                      tag: TAG_OUT_BITS'(r_p_tag), last: 1'b0};
                        end
                        n_p_valid            = 1'b1;
                        n_p_slot             = r_cmp_idx;
                        n_p_tag              = rd_tag;
                        n_active[r_cmp_idx]  = 1'b0;
                        n_fire_cnt           = RW'(r_fire_cnt + 1'b1);
                    end
                    if (r_idx < r_used) begin
                        n_cmp_valid = 1'b1;
                        n_cmp_idx   = r_idx[IW-1:0];
                        n_idx       = CW'(r_idx + 1'b1);
                    end else begin
                        n_cmp_valid = 1'b0;
                        if (!r_cmp_valid) begin
                            n_state = ST_FLUSH;
                        end
                    end
                end
            end

            ST_FLUSH: begin
                // Send out the final result of the tick
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_p_valid) begin
                        n_out = '{kind: RK_FIRED, slot: SLOT_BITS'(r_p_slot),
                                  tag: TAG_OUT_BITS'(r_p_tag), last: 1'b1};
                    end else begin
                        n_out = '{kind: RK_NONE_DUE, slot: '0, tag: '0, last: 1'b1};
                    end
                    n_p_valid = 1'b0;
                    n_state   = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_now       <= '0;
            r_used      <= '0;
            r_active    <= '0;
            r_cmp_valid <= 1'b0;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_fire_cnt  <= '0;
        end else begin
            r_state     <= n_state;
            r_now       <= n_now;
            r_used      <= n_used;
            r_active    <= n_active;
            r_cmp_valid <= n_cmp_valid;
            r_p_valid   <= n_p_valid;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
            r_fire_cnt  <= n_fire_cnt;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= n_cmp_idx;
        r_p_slot  <= n_p_slot;
        r_p_tag   <= n_p_tag;
        r_out     <= n_out;
        r_delay   <= n_delay;
        r_tag     <= n_tag;
    end

    // A pending fired result exists only while a tick is in work
    a_pending_in_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_valid |-> (r_state == ST_SCAN || r_state == ST_FLUSH))
        else $error("pending result outside a tick");

    // The used-slot count never passes the table size
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(SLOT_COUNT))
        else $error("used-slot count beyond table size");

    // A tick never reports more than the result limit
    a_fire_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fire_cnt <= RW'(MAX_RESULTS))
        else $error("fire count beyond result limit");

    // A stall keeps the slot under compare in place
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stall |=> (r_cmp_valid && r_cmp_idx == $past(r_cmp_idx)))
        else $error("stalled compare lost");

    // An accepted request closes the input until it is done
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second request taken while busy");

endmodule

`default_nettype wire

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for one_shot_event_timer_table_core
// Drives add and tick requests through the input channel with random gaps,
// predicts every result from a private copy of the event table and the tick
// count, and checks each result against the oldest prediction in order.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
    import ose_pkg::*;
();

    localparam int TABLE_SLOTS  = SLOT_COUNT_DEF;
    localparam int CLK_HALF     = 4;
    localparam int RANDOM_ITEMS = 250;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 40;
    localparam bit OP_ADD       = 1'b0;
    localparam bit OP_TICK      = 1'b1;

    // ------------------------------------------------------------------------
    // Event table predictor and in-order result store
    // ------------------------------------------------------------------------
    class timer_table_scoreboard;
        logic [TIME_BITS-1:0]    due_at [TABLE_SLOTS];
        logic [TAG_OUT_BITS-1:0] tag_of [TABLE_SLOTS];
        bit                      armed  [TABLE_SLOTS];
        int unsigned             used;
        logic [TIME_BITS-1:0]    now;
        t_result                 expected_q[$];
        int                      errors;

        function new();
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                due_at[i] = '0;
                tag_of[i] = '0;
                armed[i]  = 1'b0;
            end
            used   = 0;
            now    = '0;
            errors = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Predict the results of one accepted request
        function void note_request(bit op, logic [DELAY_BITS-1:0] delay,
                                   logic [TAG_IN_BITS-1:0] tag);
            t_result r;
            t_result held;
            int      fired;
            fired = 0;
            held  = '0;
            if (op == OP_ADD) begin
                r = '0;
                r.last = 1'b1;
                if (used >= TABLE_SLOTS) begin
                    r.kind = RK_ADD_FULL;
                end else begin
                    tag_of[used] = tag;
                    due_at[used] = now + {32'd0, delay};
                    armed[used]  = 1'b1;
                    r.kind = RK_ADD_OK;
                    r.slot = used[SLOT_BITS-1:0];
                    used++;
                end
                expected_q.push_back(r);
            end else begin
                now = now + 64'd1;
                // Scan used slots in order; hold back one result to mark last
                for (int i = 0; i < used && fired < MAX_RESULTS; i++) begin
                    if (armed[i] && due_at[i] <= now) begin
                        armed[i] = 1'b0;
                        if (fired > 0) expected_q.push_back(held);
                        held.kind = RK_FIRED;
                        held.slot = i[SLOT_BITS-1:0];
                        held.tag  = tag_of[i];
                        held.last = 1'b0;
                        fired++;
                    end
                end
                if (fired == 0) begin
                    held.kind = RK_NONE_DUE;
                    held.slot = '0;
                    held.tag  = '0;
                end
                held.last = 1'b1;
                expected_q.push_back(held);
            end
        endfunction

        // Compare one accepted result with the oldest prediction
        function void check_result(logic [1:0] kind, logic [SLOT_BITS-1:0] slot,
                                   logic [TAG_OUT_BITS-1:0] tag, logic last);
            t_result e;
            if (expected_q.size() == 0) begin
                $display("%0t: result with none expected: kind %0d slot %0d tag %h last %0d",
                         $time, kind, slot, tag, last);
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (e.kind !== kind || e.slot !== slot || e.tag !== tag || e.last !== last)
                begin
                    $display("%0t: mismatch expected kind %0d slot %0d tag %h last %0d",
                             $time, e.kind, e.slot, e.tag, e.last);
                    $display("%0t:          actual   kind %0d slot %0d tag %h last %0d",
                             $time, kind, slot, tag, last);
                    errors++;
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block under test
    // ------------------------------------------------------------------------
    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic                    i_operation;
    logic [DELAY_BITS-1:0]   i_delay;
    logic [TAG_IN_BITS-1:0]  i_event_tag;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic [1:0]              o_result_kind;
    logic [SLOT_BITS-1:0]    o_slot;
    logic [TAG_OUT_BITS-1:0] o_fired_tag;
    logic                    o_last;

    one_shot_event_timer_table_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_delay       (i_delay),
        .i_event_tag   (i_event_tag),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_result_kind (o_result_kind),
        .o_slot        (o_slot),
        .o_fired_tag   (o_fired_tag),
        .o_last        (o_last)
    );

    timer_table_scoreboard sb;
    bit calm;
    bit hold_req;
    int stall_count = 0;

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when nothing moves for too long
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    // Offer one request after a random gap and hold it until accepted
    task automatic send_request(bit op, logic [DELAY_BITS-1:0] delay,
                                logic [TAG_IN_BITS-1:0] tag);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_operation = op;
        i_delay     = delay;
        i_event_tag = tag;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(op, delay, tag);
        @(negedge i_clk);
    endtask

    // Lower valid and wait until every predicted result has come back
    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Result receiver: random stalls, one long hold on request
    // ------------------------------------------------------------------------
    initial begin
        int w;
        bit hold_done;
        hold_done   = 1'b0;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            w = calm ? 0 : $urandom_range(0, 11);
            if (hold_req && !hold_done) begin
                w = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (w > 0) begin
                i_out_ready = 1'b0;
                repeat (w) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_result(o_result_kind, o_slot, o_fired_tag, o_last);
            @(negedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        bit                     op;
        logic [DELAY_BITS-1:0]  delay;
        sb          = new();
        calm        = 1'b0;
        hold_req    = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_operation = OP_ADD;
        i_delay     = '0;
        i_event_tag = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: empty tick, delay and tag extremes, zero delay, multi-fire
        send_request(OP_TICK, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(OP_ADD, 32'h0000_0000, 16'h0000);
        send_request(OP_ADD, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(OP_ADD, 32'd1, 16'hA5A5);
        send_request(OP_ADD, 32'd1, 16'h5A5A);
        send_request(OP_TICK, 32'h0, 16'h0);
        send_request(OP_TICK, 32'h0, 16'h0);
        for (int i = 0; i < 6; i++) send_request(OP_ADD, 32'd0, 16'(16'h1000 + i));
        send_request(OP_ADD, 32'd2, 16'h8001);
        send_request(OP_TICK, 32'h0, 16'h0);
        send_request(OP_TICK, 32'h0, 16'h0);
        send_request(OP_ADD, 32'h8000_0000, 16'h7FFF);
        send_request(OP_TICK, 32'h0, 16'h0);
        send_request(OP_TICK, 32'h0, 16'h0);
        send_request(OP_TICK, 32'h0, 16'h0);

        // Random: early adds fill the table, later adds hit the full case
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = ((n / 40) % 3) == 2;
            if (n == 60) hold_req = 1'b1;
            if (n == 150) wait_drained();
            op = ($urandom_range(0, 99) < 45) ? OP_ADD : OP_TICK;
            case ($urandom_range(0, 9))
                0:       delay = $urandom();
                1:       delay = 32'd0;
                default: delay = $urandom_range(0, 40);
            endcase
            send_request(op, delay, 16'($urandom_range(0, 16'hFFFF)));
        end

        // Drain and settle, then report
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
hw/rtl/ose_pkg.sv
hw/rtl/ose_alu.sv
hw/rtl/ose_slot_mem.sv
hw/rtl/one_shot_event_timer_table_core.sv
dv/testbench.sv
